>>> design/cst_pkg.sv
// ----------------------------------------------------------------------------
// Cursor style tracker package
// Shared types and constants for the cursor style sequence tracker.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int MAX_PARAM_CHARS = 16;
   localparam int KEPT_WIDTH      = $clog2(MAX_PARAM_CHARS + 1);
   localparam int COUNT_WIDTH     = 32;
   localparam int NUMBER_WIDTH    = 32;
   localparam int BYTE_WIDTH      = 8;
   localparam int RSP_DATA_WIDTH  = 40;

   localparam logic [BYTE_WIDTH-1:0] CHAR_ESC   = 8'h1B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LBRKT = 8'h5B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_Q     = 8'h71;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SEMI  = 8'h3B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PH_GROUND = 2'd0,
      PH_ESCAPE = 2'd1,
      PH_CSI    = 2'd2,
      PH_INTER  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STYLE_BLOCK     = 2'd0,
      STYLE_UNDERLINE = 2'd1,
      STYLE_BAR       = 2'd2
   } style_type;

   typedef struct packed {
      style_type              style;
      logic                   changed;
      logic [COUNT_WIDTH-1:0] count;
   } cst_result_type;

endpackage

>>> design/cst_parser.sv
// ----------------------------------------------------------------------------
// Cursor style parser
// Escape sequence state machine with parameter collection and style state.
// ----------------------------------------------------------------------------
module cst_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [cst_pkg::BYTE_WIDTH-1:0]      byte_value,
   output cst_pkg::cst_result_type             result
);
   import cst_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic [KEPT_WIDTH-1:0]     kept_ff, kept_in;
   logic [NUMBER_WIDTH-1:0]   number_ff, number_in;
   logic                      sep_ff, sep_in;
   style_type                 style_ff, style_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      changed;
   logic                      is_digit;
   logic                      is_param;
   style_type                 picked;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_GROUND;
         kept_ff   <= '0;
         number_ff <= '0;
         sep_ff    <= 1'b0;
         style_ff  <= STYLE_BLOCK;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         kept_ff   <= kept_in;
         number_ff <= number_in;
         sep_ff    <= sep_in;
         style_ff  <= style_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      is_digit = byte_value inside {[CHAR_ZERO:CHAR_NINE]};
      is_param = is_digit || (byte_value == CHAR_SEMI);
      if (number_ff <= NUMBER_WIDTH'(2)) begin
         picked = STYLE_BLOCK;
      end else if (number_ff <= NUMBER_WIDTH'(4)) begin
         picked = STYLE_UNDERLINE;
      end else if (number_ff <= NUMBER_WIDTH'(6)) begin
         picked = STYLE_BAR;
      end else begin
         picked = style_ff;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      kept_in   = kept_ff;
      number_in = number_ff;
      sep_in    = sep_ff;
      style_in  = style_ff;
      count_in  = count_ff;
      changed   = 1'b0;
      case (phase_ff)
         PH_GROUND: begin
            if (byte_value == CHAR_ESC) begin
               phase_in = PH_ESCAPE;
            end
         end
         PH_ESCAPE: begin
            if (byte_value == CHAR_LBRKT) begin
               kept_in   = '0;
               number_in = '0;
               sep_in    = 1'b0;
               phase_in  = PH_CSI;
            end else if (byte_value != CHAR_ESC) begin
               phase_in = PH_GROUND;
            end
         end
         PH_CSI: begin
            if (is_param) begin
               if (kept_ff < KEPT_WIDTH'(MAX_PARAM_CHARS)) begin
                  kept_in = kept_ff + KEPT_WIDTH'(1);
                  if (byte_value == CHAR_SEMI) begin
                     sep_in = 1'b1;
                  end else if (!sep_ff) begin
                     number_in = {number_ff[NUMBER_WIDTH-4:0], 3'b000}
                               + {number_ff[NUMBER_WIDTH-2:0], 1'b0}
                               + {{(NUMBER_WIDTH-4){1'b0}}, byte_value[3:0]};
                  end
               end
            end else if (byte_value == CHAR_SPACE) begin
               phase_in = PH_INTER;
            end else begin
               phase_in = (byte_value == CHAR_ESC) ? PH_ESCAPE : PH_GROUND;
            end
         end
         PH_INTER: begin
            if (byte_value == CHAR_Q) begin
               if (picked != style_ff) begin
                  style_in = picked;
                  count_in = count_ff + COUNT_WIDTH'(1);
                  changed  = 1'b1;
               end
               phase_in = PH_GROUND;
            end else begin
               phase_in = (byte_value == CHAR_ESC) ? PH_ESCAPE : PH_GROUND;
            end
         end
         default: begin
            phase_in = PH_GROUND;
         end
      endcase
   end

   assign result.style   = style_in;
   assign result.changed = changed;
   assign result.count   = count_in;

   a_count_follows_change: assert property (@(posedge clock) disable iff (reset)
      step && changed |=> count_ff == $past(count_ff) + COUNT_WIDTH'(1))
      else $error("change counter did not advance on a style change");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      step && !changed |=> count_ff == $past(count_ff))
      else $error("change counter moved without a style change");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KEPT_WIDTH'(MAX_PARAM_CHARS))
      else $error("kept parameter count exceeds its limit");

   a_change_needs_final: assert property (@(posedge clock) disable iff (reset)
      changed |-> phase_ff == PH_INTER && byte_value == CHAR_Q)
      else $error("style changed outside a final byte");

endmodule

>>> design/cursor_style_sequence_tracker.sv
// ----------------------------------------------------------------------------
// Cursor style sequence tracker
// Tracks the cursor style selected by ESC [ Ps SP q in a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the response side is not stalled by
// rsp_tready, and every byte yields one result transfer. A byte waits in
// the input register until it can advance; on that advance the parser
// updates its state from it and the result register captures the result.
// The rate is set by the parser working out its next state from each byte.
module cursor_style_sequence_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [7:0] byte_value
   input  logic                                  req_tlast,  // chunk_end
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] current style, [2] style_changed, [34:3] change_count, [39:35] zero
   output logic [cst_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata
);
   import cst_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0]   in_byte_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   cst_result_type          rsp_result_ff;
   cst_result_type          result;
   logic                    advance;
   logic                    req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   cst_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .byte_value (in_byte_ff),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-COUNT_WIDTH-3){1'b0}},
                        rsp_result_ff.count,
                        rsp_result_ff.changed,
                        rsp_result_ff.style};

endmodule
